[rtl/dtc_pkg.sv]
// Shared types and constants of the decision tree classifier.
`timescale 1ns / 1ps

package dtc_pkg;

   // Fixed widths of the request and response words.
   localparam int NODE_IDX_BITS = 8;
   localparam int FEAT_IDX_BITS = 6;
   localparam int LABEL_BITS    = 8;
   localparam int FIELD_BITS    = 32;

   // Request opcodes.
   localparam logic [1:0] OP_WRITE_NODE    = 2'd0;
   localparam logic [1:0] OP_WRITE_FEATURE = 2'd1;
   localparam logic [1:0] OP_CLASSIFY      = 2'd2;

   // Everything of a node entry except its threshold.
   typedef struct packed {
      logic                     is_leaf;
      logic [FEAT_IDX_BITS-1:0] feature;
      logic [NODE_IDX_BITS-1:0] left;
      logic [NODE_IDX_BITS-1:0] right;
      logic [LABEL_BITS-1:0]    label;
   } node_link_type;

   localparam int LINK_BITS = $bits(node_link_type);

   // Outcome of one split decision.
   typedef struct packed {
      logic [NODE_IDX_BITS-1:0] next_node;
      logic                     child_ok;
   } step_result_type;

endpackage

[rtl/dtc_node_store.sv]
// Node table memory with one write port and one registered read port.
`timescale 1ns / 1ps

module dtc_node_store #(
   parameter int NODES      = 256,
   parameter int VALUE_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [$clog2(NODES)-1:0]               wr_addr,
   input  dtc_pkg::node_link_type                 wr_link,
   input  logic signed [VALUE_BITS-1:0]           wr_threshold,
   input  logic                                   rd_en,
   input  logic [$clog2(NODES)-1:0]               rd_addr,
   output dtc_pkg::node_link_type                 rd_link,
   output logic signed [VALUE_BITS-1:0]           rd_threshold
);
   import dtc_pkg::*;

   localparam int WORD_BITS = LINK_BITS + VALUE_BITS;

   logic [WORD_BITS-1:0] mem [NODES];
   logic [WORD_BITS-1:0] rd_word_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_link, wr_threshold};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   assign rd_link      = node_link_type'(rd_word_ff[WORD_BITS-1:VALUE_BITS]);
   assign rd_threshold = signed'(rd_word_ff[VALUE_BITS-1:0]);

endmodule

[rtl/dtc_feature_store.sv]
// Feature store memory with one write port and one registered read port.
`timescale 1ns / 1ps

module dtc_feature_store #(
   parameter int FEATURES   = 64,
   parameter int VALUE_BITS = 32,
   parameter int FIDX_W     = 6
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [FIDX_W-1:0]            wr_addr,
   input  logic signed [VALUE_BITS-1:0] wr_value,
   input  logic                         rd_en,
   input  logic [FIDX_W-1:0]            rd_addr,
   output logic signed [VALUE_BITS-1:0] rd_value
);
   import dtc_pkg::*;

   logic [VALUE_BITS-1:0] mem [FEATURES];
   logic [VALUE_BITS-1:0] rd_value_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_value_ff <= mem[rd_addr];
      end
   end

   assign rd_value = signed'(rd_value_ff);

endmodule

[rtl/dtc_step_unit.sv]
// Shared split unit: signed compare of feature against threshold and child choice.
`timescale 1ns / 1ps

module dtc_step_unit #(
   parameter int NODES      = 256,
   parameter int FEATURES   = 64,
   parameter int VALUE_BITS = 32
) (
   input  dtc_pkg::node_link_type       link,
   input  logic signed [VALUE_BITS-1:0] threshold,
   input  logic signed [VALUE_BITS-1:0] feature_value,
   output dtc_pkg::step_result_type     result
);
   import dtc_pkg::*;

   logic                         feat_ok;
   logic signed [VALUE_BITS-1:0] operand;
   logic                         go_left;
   logic [NODE_IDX_BITS-1:0]     child;

   always_comb begin
      // A feature index past the store reads as zero.
      feat_ok          = 32'(link.feature) < FEATURES;
      operand          = feat_ok ? feature_value : '0;
      go_left          = operand < threshold;
      child            = go_left ? link.left : link.right;
      result.next_node = child;
      result.child_ok  = 32'(child) < NODES;
   end

endmodule

[rtl/decision_tree_classifier_top.sv]
// Top level of the decision tree classifier: command port, walk sequencer and stores.
`timescale 1ns / 1ps

// Decision tree classifier. A word is taken on a rising edge with start high and busy
// low. Opcode 0 writes one node entry and opcode 1 one feature value; both give no
// response. Opcode 2 walks the tree from node 0 and gives exactly one response word,
// shown for a single cycle with rsp_valid high; the receiver cannot hold it off, so it
// must capture the word in that cycle. Opcode 3 is ignored. A classify reads node 0
// when it is accepted, then passes the node state and the feature state for each inner
// node visited, and registers the response word after the leaf check: the node table
// read and the feature store read are each registered, and one shared compare unit
// decides each split. busy stays high for the whole walk, and also while reset is
// held, so no word is taken during reset. A walk that visits NODES inner nodes, or that
// points at a child beyond the table, ends with rsp_walk_error high and label 0.
// Reading a node or feature entry that was never written gives an undefined answer.
module decision_tree_classifier_top #(
   parameter int NODES      = 256,
   parameter int FEATURES   = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_opcode,
   input  logic [dtc_pkg::NODE_IDX_BITS-1:0]   req_node_addr,
   input  logic                                req_node_is_leaf,
   input  logic [dtc_pkg::FEAT_IDX_BITS-1:0]   req_node_feature,
   input  logic signed [dtc_pkg::FIELD_BITS-1:0] req_node_threshold,
   input  logic [dtc_pkg::NODE_IDX_BITS-1:0]   req_node_left,
   input  logic [dtc_pkg::NODE_IDX_BITS-1:0]   req_node_right,
   input  logic [dtc_pkg::LABEL_BITS-1:0]      req_node_label,
   input  logic [dtc_pkg::FEAT_IDX_BITS-1:0]   req_feature_slot,
   input  logic signed [dtc_pkg::FIELD_BITS-1:0] req_feature_value,
   output logic                                rsp_valid,
   output logic [dtc_pkg::LABEL_BITS-1:0]      rsp_class_label,
   output logic                                rsp_walk_error
);
   import dtc_pkg::*;

   localparam int NIDX_W = $clog2(NODES);
   localparam int FIDX_W = (FEATURES > 1) ? $clog2(FEATURES) : 1;
   localparam int STEP_W = $clog2(NODES + 1);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_NODE = 2'd1;  // node word is on the read register
   localparam logic [1:0] ST_FEAT = 2'd2;  // feature value is on the read register

   logic [1:0]            state_ff, state_in;
   logic [STEP_W-1:0]     steps_ff, steps_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LABEL_BITS-1:0] rsp_label_ff, rsp_label_in;
   logic                  rsp_error_ff, rsp_error_in;

   logic                         accept;
   logic                         node_wr_en;
   logic [NIDX_W-1:0]            node_wr_addr;
   node_link_type                node_wr_link;
   logic signed [VALUE_BITS-1:0] node_wr_threshold;
   logic                         node_rd_en;
   logic [NIDX_W-1:0]            node_rd_addr;
   node_link_type                node_rd_link;
   logic signed [VALUE_BITS-1:0] node_rd_threshold;

   logic                         feat_wr_en;
   logic [FIDX_W-1:0]            feat_wr_addr;
   logic signed [VALUE_BITS-1:0] feat_wr_value;
   logic                         feat_rd_en;
   logic [FIDX_W-1:0]            feat_rd_addr;
   logic signed [VALUE_BITS-1:0] feat_rd_value;

   step_result_type              step;

   assign busy   = (state_ff != ST_IDLE) || reset;
   assign accept = start && !busy;

   // Incoming values are sign extended or wrapped to the stored value width.
   assign node_wr_addr              = NIDX_W'(req_node_addr);
   assign node_wr_link.is_leaf      = req_node_is_leaf;
   assign node_wr_link.feature      = req_node_feature;
   assign node_wr_link.left         = req_node_left;
   assign node_wr_link.right        = req_node_right;
   assign node_wr_link.label        = req_node_label;
   assign node_wr_threshold         = VALUE_BITS'(req_node_threshold);
   assign feat_wr_addr              = FIDX_W'(req_feature_slot);
   assign feat_wr_value             = VALUE_BITS'(req_feature_value);

   dtc_node_store #(
      .NODES      (NODES),
      .VALUE_BITS (VALUE_BITS)
   ) u_node_store (
      .clock        (clock),
      .wr_en        (node_wr_en),
      .wr_addr      (node_wr_addr),
      .wr_link      (node_wr_link),
      .wr_threshold (node_wr_threshold),
      .rd_en        (node_rd_en),
      .rd_addr      (node_rd_addr),
      .rd_link      (node_rd_link),
      .rd_threshold (node_rd_threshold)
   );

   dtc_feature_store #(
      .FEATURES   (FEATURES),
      .VALUE_BITS (VALUE_BITS),
      .FIDX_W     (FIDX_W)
   ) u_feature_store (
      .clock    (clock),
      .wr_en    (feat_wr_en),
      .wr_addr  (feat_wr_addr),
      .wr_value (feat_wr_value),
      .rd_en    (feat_rd_en),
      .rd_addr  (feat_rd_addr),
      .rd_value (feat_rd_value)
   );

   dtc_step_unit #(
      .NODES      (NODES),
      .FEATURES   (FEATURES),
      .VALUE_BITS (VALUE_BITS)
   ) u_step_unit (
      .link          (node_rd_link),
      .threshold     (node_rd_threshold),
      .feature_value (feat_rd_value),
      .result        (step)
   );

   // Walk sequencer. The node read register holds the current node for the whole
   // split, since the next node read is issued only once the split is decided.
   always_comb begin
      state_in     = state_ff;
      steps_in     = steps_ff;
      rsp_valid_in = 1'b0;
      rsp_label_in = rsp_label_ff;
      rsp_error_in = rsp_error_ff;
      node_wr_en   = 1'b0;
      feat_wr_en   = 1'b0;
      node_rd_en   = 1'b0;
      node_rd_addr = '0;
      feat_rd_en   = 1'b0;
      feat_rd_addr = FIDX_W'(node_rd_link.feature);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_WRITE_NODE: begin
                     node_wr_en = 32'(req_node_addr) < NODES;
                  end
                  OP_WRITE_FEATURE: begin
                     feat_wr_en = 32'(req_feature_slot) < FEATURES;
                  end
                  OP_CLASSIFY: begin
                     node_rd_en = 1'b1;
                     steps_in   = '0;
                     state_in   = ST_NODE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_NODE: begin
            if (steps_ff == STEP_W'(NODES)) begin
               // The walk limit is checked before the node is looked at.
               rsp_valid_in = 1'b1;
               rsp_label_in = '0;
               rsp_error_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (node_rd_link.is_leaf) begin
               rsp_valid_in = 1'b1;
               rsp_label_in = node_rd_link.label;
               rsp_error_in = 1'b0;
               state_in     = ST_IDLE;
            end else begin
               feat_rd_en = 32'(node_rd_link.feature) < FEATURES;
               state_in   = ST_FEAT;
            end
         end
         ST_FEAT: begin
            if (step.child_ok) begin
               node_rd_en   = 1'b1;
               node_rd_addr = NIDX_W'(step.next_node);
               steps_in     = steps_ff + STEP_W'(1);
               state_in     = ST_NODE;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_label_in = '0;
               rsp_error_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_label_ff <= rsp_label_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_class_label = rsp_label_ff;
   assign rsp_walk_error  = rsp_error_ff;

`ifndef SYNTHESIS
   // A response word always closes a walk that was in progress.
   a_rsp_after_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response word without a walk in progress");

   // A failed walk reports label zero.
   a_error_label: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_walk_error) |-> (rsp_class_label == '0))
      else $error("walk error with nonzero label");

   // The visit counter never runs past the walk limit.
   a_step_limit: assert property (@(posedge clock) disable iff (reset)
      32'(steps_ff) <= NODES)
      else $error("walk step counter beyond limit");

   // An accepted classify word starts a walk.
   a_classify_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_opcode == OP_CLASSIFY)) |=> busy)
      else $error("classify word did not start a walk");
`endif

endmodule

[verif/tb_decision_tree_classifier_top.sv]
// Self-checking testbench for the decision tree classifier top level.
`timescale 1ns / 1ps

// The testbench keeps a shadow copy of the node table and the feature store and walks
// that copy for every classify word the block accepts. The expected verdict (label and
// walk error) is queued at the edge that accepts the classify word. Each response
// strobe is then compared field by field with the oldest queued verdict. A strobe with
// nothing queued, a wrong field, and a verdict still queued at the end are failures.
//
// The run has two parts. The first is a short table of directed words. It covers the
// extreme threshold and feature values, signed comparison across zero, a tie (a feature
// equal to its threshold goes right), leaf nodes at low addresses and at the highest one,
// walks that loop forever and so end on the walk limit, and the unused opcode.
// Verdicts that are plain to see are typed into the table, and the other rows use the
// shadow walk. The second part loads every feature slot and then builds random trees
// rooted at node 0. Each tree is followed by a few classify words with feature rewrites
// between them. Some random node writes, feature writes and unused opcodes are mixed
// in as noise.
//
// Both stores are undefined until written. For that reason a classify word is only sent
// when the shadow walk touches nothing but written entries. Otherwise it is dropped.
module tb_decision_tree_classifier_top;

   import dtc_pkg::*;

   localparam int NODES        = 256;
   localparam int FEATURES     = 64;
   localparam int VALUE_BITS   = 32;
   localparam int CLOCK_PERIOD = 4;
   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_WORDS = 850;
   localparam int QUIET_WORDS  = 100;
   localparam int DRAIN_EVERY  = 200;
   localparam int SCRIPT_ROWS  = 25;
   // Bound on the length of a walk that hits the limit.
   localparam int WALK_CYCLES  = 2 * NODES + 8;

   // The package names no constant for the unused opcode.
   localparam logic [1:0] OP_IGNORED = 2'd3;

   // One command word, with one member for each request port.
   typedef struct packed {
      logic [1:0]               opcode;
      logic [NODE_IDX_BITS-1:0] node_addr;
      logic                     node_is_leaf;
      logic [FEAT_IDX_BITS-1:0] node_feature;
      logic [FIELD_BITS-1:0]    node_threshold;
      logic [NODE_IDX_BITS-1:0] node_left;
      logic [NODE_IDX_BITS-1:0] node_right;
      logic [LABEL_BITS-1:0]    node_label;
      logic [FEAT_IDX_BITS-1:0] feature_slot;
      logic [FIELD_BITS-1:0]    feature_value;
   } cmd_word;

   // The outcome of one classification.
   typedef struct packed {
      logic [LABEL_BITS-1:0] label;
      logic                  walk_error;
   } verdict;

   // One row of the directed table. When typed is set, the verdict in the row is the
   // expected one, and the shadow walk is not used.
   typedef struct packed {
      cmd_word w;
      logic    typed;
      verdict  v;
   } script_row;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic [1:0]                    req_opcode;
   logic [NODE_IDX_BITS-1:0]      req_node_addr;
   logic                          req_node_is_leaf;
   logic [FEAT_IDX_BITS-1:0]      req_node_feature;
   logic signed [FIELD_BITS-1:0]  req_node_threshold;
   logic [NODE_IDX_BITS-1:0]      req_node_left;
   logic [NODE_IDX_BITS-1:0]      req_node_right;
   logic [LABEL_BITS-1:0]         req_node_label;
   logic [FEAT_IDX_BITS-1:0]      req_feature_slot;
   logic signed [FIELD_BITS-1:0]  req_feature_value;
   logic                          rsp_valid;
   logic [LABEL_BITS-1:0]         rsp_class_label;
   logic                          rsp_walk_error;

   // Shadow stores, plus a flag for each entry that has been written.
   node_link_type         tree_links      [NODES];
   logic [FIELD_BITS-1:0] tree_thresholds [NODES];
   bit                    node_loaded     [NODES];
   logic [FIELD_BITS-1:0] feature_samples [FEATURES];
   bit                    sample_loaded   [FEATURES];

   // Verdicts of accepted classify words whose response has not come yet.
   verdict awaited_classes[$];

   // Nodes planned for the tree that is being grown.
   bit in_plan [NODES];
   logic [NODE_IDX_BITS-1:0] tree_plan[$];
   logic [NODE_IDX_BITS-1:0] tree_todo[$];

   script_row directed_script [SCRIPT_ROWS];

   int faults;
   int counted_words;
   int node_writes;
   int sample_writes;
   int ignored_words;
   int classes_checked;
   int walk_limits;
   int idle_odds;
   bit quiet_tail;

   decision_tree_classifier_top #(
      .NODES      (NODES),
      .FEATURES   (FEATURES),
      .VALUE_BITS (VALUE_BITS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_node_addr      (req_node_addr),
      .req_node_is_leaf   (req_node_is_leaf),
      .req_node_feature   (req_node_feature),
      .req_node_threshold (req_node_threshold),
      .req_node_left      (req_node_left),
      .req_node_right     (req_node_right),
      .req_node_label     (req_node_label),
      .req_feature_slot   (req_feature_slot),
      .req_feature_value  (req_feature_value),
      .rsp_valid          (rsp_valid),
      .rsp_class_label    (rsp_class_label),
      .rsp_walk_error     (rsp_walk_error)
   );

   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Every mismatch is printed with the simulation time and counted.
   task automatic flag_mismatch(input string what);
      $display("%0t: %s", $time, what);
      faults++;
   endtask

   // Walk the shadow tree from node 0. Here "defined" reports whether the walk
   // touched only written entries.
   function automatic verdict walk_tree(output bit defined);
      int unsigned           at;
      int unsigned           steps;
      logic [FIELD_BITS-1:0] sample;
      logic [NODE_IDX_BITS-1:0] hop;
      verdict                v;
      defined      = 1'b1;
      at           = 0;
      v.label      = '0;
      v.walk_error = 1'b1;
      for (steps = 0; steps < NODES; steps++) begin
         if (!node_loaded[at]) defined = 1'b0;
         if (tree_links[at].is_leaf) begin
            v.label      = tree_links[at].label;
            v.walk_error = 1'b0;
            return v;
         end
         sample = '0;
         if (tree_links[at].feature < FEATURES) begin
            if (!sample_loaded[tree_links[at].feature]) defined = 1'b0;
            sample = feature_samples[tree_links[at].feature];
         end
         // A tie goes right: only a strictly smaller feature takes the left child.
         hop = ($signed(sample) < $signed(tree_thresholds[at])) ?
               tree_links[at].left : tree_links[at].right;
         if (hop >= NODES) break;
         at = hop;
      end
      return v;
   endfunction

   // Present a word and hold it until an edge finds start high and busy low. At that
   // edge the word is accepted, and the shadow state and expected verdicts follow it.
   // If start is already high, it stays high, so back-to-back words do not glitch it.
   task automatic send_word(input cmd_word w, input bit typed, input verdict typed_v);
      bit     defined;
      verdict v;
      req_opcode         <= w.opcode;
      req_node_addr      <= w.node_addr;
      req_node_is_leaf   <= w.node_is_leaf;
      req_node_feature   <= w.node_feature;
      req_node_threshold <= w.node_threshold;
      req_node_left      <= w.node_left;
      req_node_right     <= w.node_right;
      req_node_label     <= w.node_label;
      req_feature_slot   <= w.feature_slot;
      req_feature_value  <= w.feature_value;
      start              <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      case (w.opcode)
         OP_WRITE_NODE: begin
            if (w.node_addr < NODES) begin
               tree_links[w.node_addr].is_leaf = w.node_is_leaf;
               tree_links[w.node_addr].feature = w.node_feature;
               tree_links[w.node_addr].left    = w.node_left;
               tree_links[w.node_addr].right   = w.node_right;
               tree_links[w.node_addr].label   = w.node_label;
               tree_thresholds[w.node_addr]    = w.node_threshold;
               node_loaded[w.node_addr]        = 1'b1;
            end
            node_writes++;
         end
         OP_WRITE_FEATURE: begin
            if (w.feature_slot < FEATURES) begin
               feature_samples[w.feature_slot] = w.feature_value;
               sample_loaded[w.feature_slot]   = 1'b1;
            end
            sample_writes++;
         end
         OP_CLASSIFY: begin
            v = walk_tree(defined);
            awaited_classes.insert(awaited_classes.size(), typed ? typed_v : v);
         end
         default: begin
            ignored_words++;
         end
      endcase
      if (w.opcode != OP_IGNORED) counted_words++;
   endtask

   // Lower start and hold it low for the given number of cycles.
   task automatic pause_sender(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Insert an idle burst now and then. Odds of zero mean no idling at all.
   task automatic maybe_idle();
      if (idle_odds != 0 && !quiet_tail && $urandom_range(1, idle_odds) == 1) begin
         pause_sender($urandom_range(1, 5));
      end
   endtask

   // Hold the sender off until every queued verdict has been answered.
   task automatic wait_for_classes();
      if (awaited_classes.size() != 0) begin
         start <= 1'b0;
         while (awaited_classes.size() != 0) @(posedge clock);
      end
   endtask

   // Mostly random full-scale values, with the extremes and the values next to zero
   // coming up often.
   function automatic logic [FIELD_BITS-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // A word with every field random, the given opcode apart.
   function automatic cmd_word noise_word(input logic [1:0] op);
      cmd_word w;
      w.opcode         = op;
      w.node_addr      = 8'($urandom);
      w.node_is_leaf   = 1'($urandom);
      w.node_feature   = 6'($urandom);
      w.node_threshold = pick_value();
      w.node_left      = 8'($urandom);
      w.node_right     = 8'($urandom);
      w.node_label     = 8'($urandom);
      w.feature_slot   = 6'($urandom);
      w.feature_value  = pick_value();
      return w;
   endfunction

   // Opcode of a noise word: a node write, a feature write or the unused opcode.
   function automatic logic [1:0] noise_opcode();
      case ($urandom_range(0, 2))
         0:       return OP_WRITE_NODE;
         1:       return OP_WRITE_FEATURE;
         default: return OP_IGNORED;
      endcase
   endfunction

   function automatic script_row node_row(input logic [7:0] addr, input logic leaf,
                                          input logic [5:0] feat, input logic [31:0] thr,
                                          input logic [7:0] lft, input logic [7:0] rgt,
                                          input logic [7:0] lab);
      script_row r;
      r.w                = noise_word(OP_WRITE_NODE);
      r.w.node_addr      = addr;
      r.w.node_is_leaf   = leaf;
      r.w.node_feature   = feat;
      r.w.node_threshold = thr;
      r.w.node_left      = lft;
      r.w.node_right     = rgt;
      r.w.node_label     = lab;
      r.typed            = 1'b0;
      r.v                = '0;
      return r;
   endfunction

   function automatic script_row sample_row(input logic [5:0] slot,
                                            input logic [31:0] val);
      script_row r;
      r.w               = noise_word(OP_WRITE_FEATURE);
      r.w.feature_slot  = slot;
      r.w.feature_value = val;
      r.typed           = 1'b0;
      r.v               = '0;
      return r;
   endfunction

   function automatic script_row classify_row(input logic typed, input logic [7:0] lab,
                                              input logic err);
      script_row r;
      r.w            = noise_word(OP_CLASSIFY);
      r.typed        = typed;
      r.v.label      = lab;
      r.v.walk_error = err;
      return r;
   endfunction

   // The unused opcode, with every other field all ones or all zeros.
   function automatic script_row ignored_row(input logic ones);
      script_row r;
      r.w        = ones ? '1 : '0;
      r.w.opcode = OP_IGNORED;
      r.typed    = 1'b0;
      r.v        = '0;
      return r;
   endfunction

   // Choose a child for an inner node. Usually this is a fresh address, which joins
   // the plan. Now and then it is a node already planned, which can close a loop.
   function automatic logic [NODE_IDX_BITS-1:0] pick_child();
      logic [NODE_IDX_BITS-1:0] c;
      if ($urandom_range(0, 15) == 0) begin
         return tree_plan[$urandom_range(0, tree_plan.size() - 1)];
      end
      c = 8'($urandom);
      while (in_plan[c]) c = c + 8'd1;
      in_plan[c] = 1'b1;
      tree_plan.insert(tree_plan.size(), c);
      tree_todo.insert(tree_todo.size(), c);
      return c;
   endfunction

   // Grow a random tree of a few levels, rooted at node 0. Every node it can reach is
   // written before the tree is used.
   task automatic grow_tree();
      int unsigned              budget;
      logic [NODE_IDX_BITS-1:0] at;
      cmd_word                  w;
      budget = $urandom_range(1, 12);
      foreach (in_plan[i]) in_plan[i] = 1'b0;
      tree_plan.delete();
      tree_todo.delete();
      in_plan[0] = 1'b1;
      tree_plan.insert(tree_plan.size(), 8'd0);
      tree_todo.insert(tree_todo.size(), 8'd0);
      while (tree_todo.size() != 0) begin
         at             = tree_todo.pop_front();
         w              = noise_word(OP_WRITE_NODE);
         w.node_addr    = at;
         w.node_is_leaf = (tree_plan.size() + 2 > budget) || ($urandom_range(0, 3) == 0);
         if (!w.node_is_leaf) begin
            w.node_left  = pick_child();
            w.node_right = pick_child();
         end
         maybe_idle();
         send_word(w, 1'b0, '0);
      end
   endtask

   // Send a classify word, but only if its walk stays inside written entries.
   task automatic try_classify();
      bit defined;
      void'(walk_tree(defined));
      if (defined) begin
         maybe_idle();
         send_word(noise_word(OP_CLASSIFY), 1'b0, '0);
      end
   endtask

   // Response checker. The receiver cannot stall, so every strobe is taken as it comes.
   always @(posedge clock) begin : check_classes
      verdict want;
      if (!reset && rsp_valid === 1'b1) begin
         if (awaited_classes.size() == 0) begin
            flag_mismatch($sformatf(
               "response with no classify pending: expected none, actual label %0d error %b",
               rsp_class_label, rsp_walk_error));
         end else begin
            want = awaited_classes.pop_front();
            classes_checked++;
            if (rsp_walk_error === 1'b1) walk_limits++;
            if (rsp_walk_error !== want.walk_error) begin
               flag_mismatch($sformatf("walk_error expected %b actual %b",
                                       want.walk_error, rsp_walk_error));
            end
            if (rsp_class_label !== want.label) begin
               flag_mismatch($sformatf("class_label expected %0d actual %0d",
                                       want.label, rsp_class_label));
            end
         end
      end
   end

   initial begin : stimulus
      int word_goal;
      int next_drain;
      int guard;
      cmd_word w;
      faults          = 0;
      counted_words   = 0;
      node_writes     = 0;
      sample_writes   = 0;
      ignored_words   = 0;
      classes_checked = 0;
      walk_limits     = 0;
      idle_odds       = 4;
      quiet_tail      = 1'b0;
      foreach (tree_links[i]) begin
         tree_links[i]      = '0;
         tree_thresholds[i] = '0;
         node_loaded[i]     = 1'b0;
      end
      foreach (feature_samples[i]) begin
         feature_samples[i] = '0;
         sample_loaded[i]   = 1'b0;
      end

      // Directed table. Feature 0 starts at the largest value and feature 63 at the
      // smallest. The root then tests each of them against an equal threshold and
      // against a threshold one step off.
      directed_script[0]  = ignored_row(1'b1);
      directed_script[1]  = sample_row(6'd0, 32'h7FFF_FFFF);
      directed_script[2]  = sample_row(6'd63, 32'h8000_0000);
      directed_script[3]  = node_row(8'd0, 1'b0, 6'd0, 32'h7FFF_FFFF, 8'd1, 8'd2, 8'd0);
      directed_script[4]  = node_row(8'd1, 1'b1, 6'd0, 32'd0, 8'd0, 8'd0, 8'h00);
      directed_script[5]  = node_row(8'd2, 1'b1, 6'd63, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
      // Largest feature equal to the largest threshold goes right, to the leaf at node 2.
      directed_script[6]  = classify_row(1'b1, 8'hFF, 1'b0);
      directed_script[7]  = sample_row(6'd0, 32'h7FFF_FFFE);
      directed_script[8]  = classify_row(1'b1, 8'h00, 1'b0);
      directed_script[9]  = node_row(8'd3, 1'b1, 6'd0, 32'd0, 8'd0, 8'd0, 8'hA5);
      directed_script[10] = node_row(8'd255, 1'b1, 6'd63, 32'h8000_0000, 8'hFF, 8'hFF,
                                     8'h5A);
      directed_script[11] = node_row(8'd0, 1'b0, 6'd63, 32'h8000_0000, 8'd255, 8'd3, 8'd0);
      // Smallest feature against the smallest threshold is a tie, so the walk goes right.
      directed_script[12] = classify_row(1'b1, 8'hA5, 1'b0);
      directed_script[13] = node_row(8'd0, 1'b0, 6'd63, 32'h8000_0001, 8'd255, 8'd3, 8'd0);
      directed_script[14] = classify_row(1'b1, 8'h5A, 1'b0);
      // The root points back at itself on both sides, so the walk limit ends it.
      directed_script[15] = node_row(8'd0, 1'b0, 6'd0, 32'd0, 8'd0, 8'd0, 8'd0);
      directed_script[16] = classify_row(1'b1, 8'h00, 1'b1);
      // A two-node loop between the root and node 4.
      directed_script[17] = node_row(8'd4, 1'b0, 6'd63, 32'd0, 8'd0, 8'd0, 8'd0);
      directed_script[18] = node_row(8'd0, 1'b0, 6'd0, 32'd0, 8'd4, 8'd4, 8'd0);
      directed_script[19] = classify_row(1'b1, 8'h00, 1'b1);
      // -1 against +1 only goes left if the compare is signed.
      directed_script[20] = sample_row(6'd0, 32'hFFFF_FFFF);
      directed_script[21] = node_row(8'd0, 1'b0, 6'd0, 32'd1, 8'd3, 8'd2, 8'd0);
      directed_script[22] = classify_row(1'b0, 8'h00, 1'b0);
      directed_script[23] = ignored_row(1'b0);
      directed_script[24] = classify_row(1'b0, 8'h00, 1'b0);

      reset              = 1'b1;
      start              = 1'b0;
      req_opcode         = '0;
      req_node_addr      = '0;
      req_node_is_leaf   = 1'b0;
      req_node_feature   = '0;
      req_node_threshold = '0;
      req_node_left      = '0;
      req_node_right     = '0;
      req_node_label     = '0;
      req_feature_slot   = '0;
      req_feature_value  = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_script[i]) begin
         maybe_idle();
         send_word(directed_script[i].w, directed_script[i].typed, directed_script[i].v);
      end
      wait_for_classes();

      // Random part. Every feature slot is loaded first, so that random trees may test
      // any feature.
      word_goal  = counted_words + RANDOM_WORDS;
      next_drain = counted_words + DRAIN_EVERY;
      for (int s = 0; s < FEATURES; s++) begin
         w              = noise_word(OP_WRITE_FEATURE);
         w.feature_slot = 6'(s);
         maybe_idle();
         send_word(w, 1'b0, '0);
      end
      while (counted_words < word_goal) begin
         quiet_tail = (counted_words + QUIET_WORDS >= word_goal);
         // Some trees run with no idling at all, others with heavy idling.
         case ($urandom_range(0, 2))
            0:       idle_odds = 0;
            1:       idle_odds = 3;
            default: idle_odds = 8;
         endcase
         grow_tree();
         repeat ($urandom_range(1, 6)) begin
            repeat ($urandom_range(0, 3)) begin
               maybe_idle();
               send_word(noise_word(OP_WRITE_FEATURE), 1'b0, '0);
            end
            // Noise: a stray node write, feature write or unused opcode. A stray node
            // write can break the tree. The shadow walk then holds classify words back
            // until the next tree is grown.
            if ($urandom_range(0, 5) == 0) begin
               maybe_idle();
               send_word(noise_word(noise_opcode()), 1'b0, '0);
            end
            try_classify();
         end
         if (counted_words >= next_drain) begin
            wait_for_classes();
            next_drain += DRAIN_EVERY;
         end
      end

      // Wait for the last verdicts, with a limit, and then a little longer for any
      // response that should not come.
      start <= 1'b0;
      guard = 0;
      while (awaited_classes.size() != 0 && guard < 4 * WALK_CYCLES) begin
         @(posedge clock);
         guard++;
      end
      repeat (16) @(posedge clock);
      while (awaited_classes.size() != 0) begin
         flag_mismatch($sformatf("no response: expected label %0d error %b, actual none",
                                 awaited_classes[0].label, awaited_classes[0].walk_error));
         void'(awaited_classes.pop_front());
      end

      $display("Ran %0d words: %0d node writes, %0d feature writes, %0d unused opcodes.",
               counted_words + ignored_words, node_writes, sample_writes, ignored_words);
      $display("Checked %0d classifications, %0d of them ended by the walk limit.",
               classes_checked, walk_limits);
      if (faults == 0) begin
         $display("[decision_tree_classifier_top] OK");
      end else begin
         $display("[decision_tree_classifier_top] ERROR");
      end
      $finish;
   end

   // A correct run takes well under a millisecond. This covers even every word
   // running into the walk limit after a full idle burst.
   initial begin : watchdog
      #8_000_000;
      $display("Timed out with %0d classifications still pending.", awaited_classes.size());
      $display("[decision_tree_classifier_top] ERROR");
      $finish;
   end

endmodule

[filelist.f]
rtl/dtc_pkg.sv
rtl/dtc_node_store.sv
rtl/dtc_feature_store.sv
rtl/dtc_step_unit.sv
rtl/decision_tree_classifier_top.sv
verif/tb_decision_tree_classifier_top.sv
